[sv/dfr_pkg.sv]
// ----------------------------------------------------------------------------
// Delimited frame receiver package
// Word types, register indexes and reset constants shared by the receiver.
// ----------------------------------------------------------------------------
package dfr_pkg;

    // Store depth used when the top level is not given another one.
    localparam int DEFAULT_DEPTH = 64;

    // Configuration register indexes and their reset values.
    localparam int          CFG_INDEX_W      = 8;
    localparam int          CFG_DATA_W       = 8;
    localparam logic [7:0]  REG_START_MARKER = 8'd0;
    localparam logic [7:0]  REG_END_MARKER   = 8'd1;
    localparam logic [7:0]  START_RESET      = 8'h3c;
    localparam logic [7:0]  END_RESET        = 8'h3e;

    // Id reported when no frame is pending.
    localparam logic [7:0]  NO_ID            = 8'd255;

    // Input word kinds.
    localparam logic        KIND_BYTE        = 1'b0;
    localparam logic        KIND_READ        = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } dfr_in_t;

    typedef struct packed {
        logic       frame_ready;
        logic [7:0] msg_id;
        logic [5:0] frame_length;
        logic [7:0] data_byte;
        logic       has_data;
        logic       last;
    } dfr_out_t;

endpackage

[sv/delimited_frame_receiver_top.sv]
// A read with no payload has its word in the output register the cycle after acceptance;
// payload words pass from the store via the read stage to the output. Throughput: one
// received byte per cycle while the output is free; a read of length L streams L-2 words
// at one per cycle while m_ready holds, set by the store's single read port, and blocks
// input until drained. Reset (aresetn, synchronous, active low) clears index and pending
// flag, resets markers; the store needs no clearing, as only entries written since reset are read.
// ----------------------------------------------------------------------------
// Delimited frame receiver
// Assembles one marker-delimited frame into a byte store and streams it out
// on request as id, length and one payload byte per word.
// ----------------------------------------------------------------------------
module delimited_frame_receiver_top #(
    parameter int BUFFER_DEPTH = dfr_pkg::DEFAULT_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  dfr_pkg::dfr_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output dfr_pkg::dfr_out_t                   m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dfr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dfr_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import dfr_pkg::*;

    localparam int IW = $clog2(BUFFER_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    // Control and configuration registers.
    logic           state_reg,   state_next;
    logic [IW-1:0]  wi_reg,      wi_next;
    logic           pending_reg, pending_next;
    logic [7:0]     start_reg;
    logic [7:0]     end_reg;
    logic [7:0]     id_reg,      id_next;
    logic [IW-1:0]  len_reg,     len_next;
    logic [IW-1:0]  ptr_reg,     ptr_next;
    logic           s1_valid_reg, s1_valid_next;
    logic           s1_last_reg,  s1_last_next;
    logic           out_valid_reg, out_valid_next;
    dfr_out_t       out_reg,     out_next;

    // Store access.
    logic           wr_en;
    logic [IW-1:0]  wr_addr;
    logic [7:0]     rd_data;

    logic           in_fire;
    logic           out_free;
    logic           s1_move;
    logic           issue;
    logic           issue_last;

    dfr_store #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (IW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_data.rx_byte),
        .rd_en   (issue),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    // Handshake and pipeline movement.
    assign out_free   = !out_valid_reg || m_ready;
    assign s1_move    = s1_valid_reg && out_free;
    assign issue      = (state_reg == ST_READ) && (!s1_valid_reg || s1_move);
    assign issue_last = (IW'(ptr_reg + 1'b1) == len_reg);
    assign s_ready    = (state_reg == ST_IDLE) && !s1_valid_reg && out_free;
    assign in_fire    = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_reg;

    // Next-state logic for assembly, readout sequencing and the output word.
    always_comb begin
        state_next     = state_reg;
        wi_next        = wi_reg;
        pending_next   = pending_reg;
        id_next        = id_reg;
        len_next       = len_reg;
        ptr_next       = ptr_reg;
        s1_valid_next  = s1_valid_reg;
        s1_last_next   = s1_last_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        wr_en          = 1'b0;
        wr_addr        = wi_reg;

        // Drain the output register, then refill it from the read stage.
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (s1_move) begin
            out_next.frame_ready  = 1'b1;
            out_next.msg_id       = id_reg;
            out_next.frame_length = 6'(len_reg);
            out_next.data_byte    = rd_data;
            out_next.has_data     = 1'b1;
            out_next.last         = s1_last_reg;
            out_valid_next        = 1'b1;
            s1_valid_next         = 1'b0;
        end

        // Issue one payload read per cycle while the stages have room.
        if (issue) begin
            s1_valid_next = 1'b1;
            s1_last_next  = issue_last;
            ptr_next      = IW'(ptr_reg + 1'b1);
            if (issue_last) begin
                state_next = ST_IDLE;
            end
        end

        // Accepted input word.
        if (in_fire) begin
            if (s_data.kind == KIND_BYTE) begin
                if (!pending_reg) begin
                    if (s_data.rx_byte == end_reg) begin
                        pending_next = 1'b1;
                    end else begin
                        if (s_data.rx_byte == start_reg) begin
                            wr_addr = '0;
                        end
                        wr_en   = 1'b1;
                        wi_next = (wr_addr == IW'(BUFFER_DEPTH - 1)) ? '0
                                                                     : IW'(wr_addr + 1'b1);
                        // Entry 1 is mirrored so the id never needs a store read.
                        if (wr_addr == IW'(1)) begin
                            id_next = s_data.rx_byte;
                        end
                    end
                end
            end else if (!pending_reg) begin
                out_next.frame_ready  = 1'b0;
                out_next.msg_id       = NO_ID;
                out_next.frame_length = '0;
                out_next.data_byte    = '0;
                out_next.has_data     = 1'b0;
                out_next.last         = 1'b1;
                out_valid_next        = 1'b1;
            end else begin
                pending_next = 1'b0;
                len_next     = wi_reg;
                if (wi_reg < IW'(3)) begin
                    out_next.frame_ready  = 1'b1;
                    out_next.msg_id       = id_reg;
                    out_next.frame_length = 6'(wi_reg);
                    out_next.data_byte    = '0;
                    out_next.has_data     = 1'b0;
                    out_next.last         = 1'b1;
                    out_valid_next        = 1'b1;
                end else begin
                    state_next = ST_READ;
                    ptr_next   = IW'(2);
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wi_reg        <= '0;
            pending_reg   <= 1'b0;
            id_reg        <= '0;
            ptr_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wi_reg        <= wi_next;
            pending_reg   <= pending_next;
            id_reg        <= id_next;
            ptr_reg       <= ptr_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        len_reg     <= len_next;
        s1_last_reg <= s1_last_next;
        out_reg     <= out_next;
    end

    // Marker registers, written through the configuration channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= START_RESET;
            end_reg   <= END_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_START_MARKER) begin
                start_reg <= cfg_data;
            end else if (cfg_index == REG_END_MARKER) begin
                end_reg <= cfg_data;
            end
        end
    end

endmodule

[sv/dfr_store.sv]
// ----------------------------------------------------------------------------
// Frame byte store
// Single-port-write, single-port-read synchronous memory with a registered
// read that updates only when a read is issued.
// ----------------------------------------------------------------------------
module dfr_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
